### rtl/core/rv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_pkg
// Shared constants, status codes, rounding and saturation helpers for the refraction
// vector datapath.
// ----------------------------------------------------------------------------
package rv_pkg;

  // Fraction bits of the vector ports and of the internal unit-scale values.
  localparam int VECTOR_FRAC_BITS = 16;
  localparam int IFRAC            = 30;

  // Port field widths.
  localparam int INC_W  = 32;
  localparam int NRM_W  = 18;
  localparam int IDX_W  = 16;
  localparam int OUT_W  = 18;
  localparam int STAT_W = 2;

  // Pipelined square root: one root bit per stage.
  localparam int ROOT_W      = 32;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SQRT_STAGES = ROOT_W;

  // Pipelined restoring divider: one quotient bit per stage.
  localparam int QUO_W      = 34;
  localparam int DIVD_W     = 64;
  localparam int DIVS_W     = 32;
  localparam int DIV_STAGES = QUO_W;

  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  typedef enum logic [STAT_W-1:0] {
    ST_REFRACTED = 2'd0,
    ST_TIR       = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  // Arithmetic right shift by s (s > 0), rounded to nearest, ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Saturate to the signed output format.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/core/rv_ray_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_ray_if
// Input channel: one ray word per handshake.
// ----------------------------------------------------------------------------
interface rv_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] incident_x;
  logic signed [31:0] incident_y;
  logic signed [31:0] incident_z;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic        [15:0] index_inside;
  logic        [15:0] index_outside;

  modport source (output valid, incident_x, incident_y, incident_z, normal_x, normal_y,
                  normal_z, index_inside, index_outside, input ready);
  modport sink (input valid, incident_x, incident_y, incident_z, normal_x, normal_y,
                normal_z, index_inside, index_outside, output ready);
endinterface

### rtl/core/rv_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_result_if
// Output channel: one refracted vector word per handshake.
// ----------------------------------------------------------------------------
interface rv_result_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] refracted_x;
  logic signed [17:0] refracted_y;
  logic signed [17:0] refracted_z;
  logic        [1:0]  status;

  modport source (output valid, refracted_x, refracted_y, refracted_z, status, input ready);
  modport sink (input valid, refracted_x, refracted_y, refracted_z, status, output ready);
endinterface

### rtl/core/rv_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_isqrt
// Pipelined truncated integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module rv_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rv_pkg::RAD_W-1:0]   radicand,
  output logic [rv_pkg::ROOT_W-1:0]  root
);
  import rv_pkg::*;

  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam int B = SQRT_STAGES - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Setting bit B adds 2^(B+1)*root + 2^(2B) to the square.
    assign trial = ((RAD_W+2)'(root_in) << (B + 1)) | ((RAD_W+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rem_in} >= trial) begin
          rem_q[k]  <= RAD_W'({2'b00, rem_in} - trial);
          root_q[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

### rtl/core/rv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits, that is the numerator shifted down by QUO_W is below the
// divisor.
// ----------------------------------------------------------------------------
module rv_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rv_pkg::DIVD_W-1:0]  numer,
  input  logic [rv_pkg::DIVS_W-1:0]  denom,
  output logic [rv_pkg::QUO_W-1:0]   quo
);
  import rv_pkg::*;

  logic [DIVS_W-1:0] rem_q [DIV_STAGES];
  logic [DIVS_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0]  low_q [DIV_STAGES];
  logic [QUO_W-1:0]  quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [DIVS_W-1:0] rem_in;
    logic [DIVS_W-1:0] den_in;
    logic [QUO_W-1:0]  low_in;
    logic [QUO_W-1:0]  quo_in;
    logic [DIVS_W:0]   part;

    if (k == 0) begin : g_first
      assign rem_in = DIVS_W'(numer[DIVD_W-1:QUO_W]);
      assign den_in = denom;
      assign low_in = numer[QUO_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Bring down the next numerator bit and try a subtract.
    assign part = {rem_in, low_in[QUO_W-1-k]};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= den_in;
        low_q[k] <= low_in;
        if (part >= {1'b0, den_in}) begin
          rem_q[k] <= DIVS_W'(part - {1'b0, den_in});
          quo_q[k] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - k));
        end else begin
          rem_q[k] <= DIVS_W'(part);
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

### rtl/core/refraction_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refraction_vector
// Snell refraction of an incident ray through a surface with a unit normal.
// ----------------------------------------------------------------------------
// The block takes one ray word per cycle while the output is not stalled, and
// returns one result word per ray, in order. It is built from two pipelined
// square roots (32 stages each, one root bit per stage) and two rows of
// pipelined dividers (34 stages each, one quotient bit per stage), joined by
// short multiply and add stages. The whole pipeline advances together: it
// holds when a finished word waits at the output and is not taken, and moves
// on again as soon as it is. A zero incident vector or a zero index gives a
// zero vector with status invalid; total internal reflection gives a zero
// vector with status TIR.
module refraction_vector (
  input logic           clk,
  input logic           rst,
  rv_ray_if.sink        ray,
  rv_result_if.source   result
);
  import rv_pkg::*;

  typedef struct packed {
    logic                        inv;
    logic                        dneg;
    logic [2:0][31:0]            mn;
    logic [2:0]                  neg;
    logic [2:0][NRM_W-1:0]       nrm;
    logic [IDX_W-1:0]            a;
    logic [IDX_W-1:0]            b;
  } side_a_t;

  typedef struct packed {
    logic                        inv;
    logic                        dneg;
    logic [2:0]                  neg;
    logic [2:0][NRM_W-1:0]       nrm;
    logic [IDX_W-1:0]            a;
    logic [IDX_W-1:0]            b;
  } side_b_t;

  typedef struct packed {
    logic                        inv;
    logic                        tir;
    logic [2:0]                  povf;
    logic [2:0]                  pneg;
    logic [2:0][NRM_W:0]         nn;
  } side_c_t;

  typedef struct packed {
    logic                        inv;
    logic                        tir;
    logic [2:0][35:0]            p;
    logic [2:0][NRM_W:0]         nn;
  } side_d_t;

  // Global advance: the pipeline moves when the output word is empty or taken.
  logic adv;
  logic o_valid;

  assign adv       = !o_valid || result.ready;
  assign ray.ready = adv;

  // Valid bits of every stage.
  logic s1_v, s2_v, s3_v, s4_v;
  logic [SQRT_STAGES-1:0] va_line;
  logic [DIV_STAGES-1:0]  vb_line;
  logic s6_v, s7_v, s8_v, s9_v, s10_v, s11_v, s12_v, s13_v, s14_v;
  logic [DIV_STAGES-1:0]  vc_line;
  logic [SQRT_STAGES-1:0] vd_line;
  logic s16_v, s17_v;

  // Payload registers.
  logic signed [INC_W-1:0]  s1_inc [3];
  logic signed [NRM_W-1:0]  s1_nrm [3];
  logic [IDX_W-1:0]         s1_a, s1_b;

  logic                     s2_inv;
  logic [31:0]              s2_mn  [3];
  logic [2:0]               s2_neg;
  logic signed [NRM_W-1:0]  s2_nrm [3];
  logic [IDX_W-1:0]         s2_a, s2_b;
  logic signed [49:0]       s2_pd  [3];

  side_a_t                  s3_side;
  logic [63:0]              s3_sq  [3];

  side_a_t                  s4_side;
  logic [RAD_W-1:0]         s4_sumsq;

  side_a_t                  line_a [SQRT_STAGES];
  side_b_t                  line_b [DIV_STAGES];
  logic [ROOT_W-1:0]        len;
  logic [DIVD_W-1:0]        div1_num [3];
  logic [QUO_W-1:0]         div1_quo [3];

  logic                     s6_inv;
  logic signed [31:0]       s6_dir [3];
  logic signed [NRM_W:0]    s6_nn  [3];
  logic [IDX_W-1:0]         s6_num, s6_den;

  logic                     s7_inv;
  logic signed [31:0]       s7_dir [3];
  logic signed [NRM_W:0]    s7_nn  [3];
  logic signed [50:0]       s7_pdn [3];
  logic [IDX_W-1:0]         s7_num, s7_den;
  logic [31:0]              s7_den2;

  logic                     s8_inv;
  logic signed [31:0]       s8_dir [3];
  logic signed [NRM_W:0]    s8_nn  [3];
  logic signed [52:0]       s8_dsum;
  logic [IDX_W-1:0]         s8_num, s8_den;
  logic [31:0]              s8_den2;

  logic                     s9_inv;
  logic signed [31:0]       s9_dir [3];
  logic signed [NRM_W:0]    s9_nn  [3];
  logic signed [31:0]       s9_d;
  logic [IDX_W-1:0]         s9_num, s9_den;
  logic [31:0]              s9_den2;

  logic                     s10_inv;
  logic signed [31:0]       s10_dir [3];
  logic signed [NRM_W:0]    s10_nn  [3];
  logic signed [63:0]       s10_dd;
  logic signed [50:0]       s10_dn  [3];
  logic [31:0]              s10_nnum;
  logic [IDX_W-1:0]         s10_num, s10_den;
  logic [31:0]              s10_den2;

  logic                     s11_inv;
  logic signed [NRM_W:0]    s11_nn [3];
  logic [30:0]              s11_e;
  logic signed [33:0]       s11_t  [3];
  logic [31:0]              s11_nnum;
  logic [IDX_W-1:0]         s11_num, s11_den;
  logic [31:0]              s11_den2;

  logic                     s12_inv;
  logic signed [NRM_W:0]    s12_nn  [3];
  logic [62:0]              s12_nne;
  logic [49:0]              s12_pm  [3];
  logic [2:0]               s12_pneg;
  logic [IDX_W-1:0]         s12_den;
  logic [31:0]              s12_den2;

  logic                     s13_inv;
  logic signed [NRM_W:0]    s13_nn  [3];
  logic signed [63:0]       s13_detnum;
  logic [50:0]              s13_pnum [3];
  logic [2:0]               s13_pneg;
  logic [IDX_W-1:0]         s13_den;
  logic [31:0]              s13_den2;

  side_c_t                  s14_side;
  logic [DIVD_W-1:0]        s14_dnum;
  logic [50:0]              s14_pnum [3];
  logic [IDX_W-1:0]         s14_den;
  logic [31:0]              s14_den2;

  side_c_t                  line_c [DIV_STAGES];
  side_d_t                  line_d [SQRT_STAGES];
  logic [QUO_W-1:0]         detq;
  logic [QUO_W-1:0]         pquo [3];
  side_d_t                  side_d_in;
  logic [ROOT_W-1:0]        sq;

  logic                     s16_inv, s16_tir;
  logic signed [35:0]       s16_p  [3];
  logic signed [51:0]       s16_qp [3];

  logic                     s17_inv, s17_tir;
  logic signed [37:0]       s17_diff [3];

  logic signed [OUT_W-1:0]  o_res [3];
  logic [STAT_W-1:0]        o_status;

  // Valid bits travel with their words.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_v    <= 1'b0;
      va_line <= '0;
      vb_line <= '0;
      s6_v    <= 1'b0;
      s7_v    <= 1'b0;
      s8_v    <= 1'b0;
      s9_v    <= 1'b0;
      s10_v   <= 1'b0;
      s11_v   <= 1'b0;
      s12_v   <= 1'b0;
      s13_v   <= 1'b0;
      s14_v   <= 1'b0;
      vc_line <= '0;
      vd_line <= '0;
      s16_v   <= 1'b0;
      s17_v   <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      s1_v    <= ray.valid;
      s2_v    <= s1_v;
      s3_v    <= s2_v;
      s4_v    <= s3_v;
      va_line <= {va_line[SQRT_STAGES-2:0], s4_v};
      vb_line <= {vb_line[DIV_STAGES-2:0], va_line[SQRT_STAGES-1]};
      s6_v    <= vb_line[DIV_STAGES-1];
      s7_v    <= s6_v;
      s8_v    <= s7_v;
      s9_v    <= s8_v;
      s10_v   <= s9_v;
      s11_v   <= s10_v;
      s12_v   <= s11_v;
      s13_v   <= s12_v;
      s14_v   <= s13_v;
      vc_line <= {vc_line[DIV_STAGES-2:0], s14_v};
      vd_line <= {vd_line[SQRT_STAGES-2:0], vc_line[DIV_STAGES-1]};
      s16_v   <= vd_line[SQRT_STAGES-1];
      s17_v   <= s16_v;
      o_valid <= s17_v;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_inc[0] <= ray.incident_x;
      s1_inc[1] <= ray.incident_y;
      s1_inc[2] <= ray.incident_z;
      s1_nrm[0] <= ray.normal_x;
      s1_nrm[1] <= ray.normal_y;
      s1_nrm[2] <= ray.normal_z;
      s1_a      <= ray.index_inside;
      s1_b      <= ray.index_outside;
    end
  end

  // Magnitudes, normalising shift and incident-normal products.
  logic [31:0] mag_c [3];
  logic [31:0] maxm_c;
  logic        zero_c;

  always_comb begin
    maxm_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = s1_inc[i][INC_W-1] ? 32'(-s1_inc[i]) : 32'(s1_inc[i]);
      if (mag_c[i] > maxm_c) begin
        maxm_c = mag_c[i];
      end
    end
    // Binary search for the left shift that brings the largest magnitude
    // into [2^30, 2^31].
    for (int k = 4; k >= 0; k--) begin
      if (maxm_c < (32'd1 << (IFRAC + 1 - (1 << k)))) begin
        maxm_c = maxm_c << (1 << k);
        for (int i = 0; i < 3; i++) begin
          mag_c[i] = mag_c[i] << (1 << k);
        end
      end
    end
    zero_c = (s1_inc[0] == '0 && s1_inc[1] == '0 && s1_inc[2] == '0) ||
             s1_a == '0 || s1_b == '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inv <= zero_c;
      s2_a   <= s1_a;
      s2_b   <= s1_b;
      for (int i = 0; i < 3; i++) begin
        s2_mn[i]  <= mag_c[i];
        s2_neg[i] <= s1_inc[i][INC_W-1];
        s2_nrm[i] <= s1_nrm[i];
        s2_pd[i]  <= s1_inc[i] * s1_nrm[i];
      end
    end
  end

  // Sign of the incident-normal dot product, and squared magnitudes.
  logic signed [51:0] dot_c;
  assign dot_c = 52'(s2_pd[0]) + 52'(s2_pd[1]) + 52'(s2_pd[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side.inv  <= s2_inv;
      s3_side.dneg <= dot_c[51];
      s3_side.neg  <= s2_neg;
      s3_side.a    <= s2_a;
      s3_side.b    <= s2_b;
      for (int i = 0; i < 3; i++) begin
        s3_side.mn[i]  <= s2_mn[i];
        s3_side.nrm[i] <= s2_nrm[i];
        s3_sq[i]       <= 64'(s2_mn[i]) * 64'(s2_mn[i]);
      end
    end
  end

  // Sum of squares.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side  <= s3_side;
      s4_sumsq <= s3_sq[0] + s3_sq[1] + s3_sq[2];
    end
  end

  // Vector length.
  rv_isqrt u_len_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (s4_sumsq),
    .root     (len)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      line_a[0] <= s4_side;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        line_a[k] <= line_a[k-1];
      end
    end
  end

  // Normalised components: round(m * 2^30 / len).
  for (genvar i = 0; i < 3; i++) begin : g_norm
    assign div1_num[i] = {2'b00, line_a[SQRT_STAGES-1].mn[i], 30'd0} +
                         DIVD_W'(len >> 1);
    rv_div u_norm_div (
      .clk   (clk),
      .en    (adv),
      .numer (div1_num[i]),
      .denom (len),
      .quo   (div1_quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_b[0].inv  <= line_a[SQRT_STAGES-1].inv;
      line_b[0].dneg <= line_a[SQRT_STAGES-1].dneg;
      line_b[0].neg  <= line_a[SQRT_STAGES-1].neg;
      line_b[0].nrm  <= line_a[SQRT_STAGES-1].nrm;
      line_b[0].a    <= line_a[SQRT_STAGES-1].a;
      line_b[0].b    <= line_a[SQRT_STAGES-1].b;
      for (int k = 1; k < DIV_STAGES; k++) begin
        line_b[k] <= line_b[k-1];
      end
    end
  end

  // Direction (negated incident), side of the surface and index ratio.
  side_b_t sb;
  assign sb = line_b[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_inv <= sb.inv;
      s6_num <= sb.dneg ? sb.b : sb.a;
      s6_den <= sb.dneg ? sb.a : sb.b;
      for (int i = 0; i < 3; i++) begin
        s6_dir[i] <= sb.neg[i] ? $signed(div1_quo[i][31:0]) : -$signed(div1_quo[i][31:0]);
        s6_nn[i]  <= sb.dneg ? (NRM_W+1)'($signed(sb.nrm[i]))
                             : -(NRM_W+1)'($signed(sb.nrm[i]));
      end
    end
  end

  // Products for d and the squared denominator.
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_inv  <= s6_inv;
      s7_num  <= s6_num;
      s7_den  <= s6_den;
      s7_den2 <= 32'(s6_den) * 32'(s6_den);
      for (int i = 0; i < 3; i++) begin
        s7_dir[i] <= s6_dir[i];
        s7_nn[i]  <= s6_nn[i];
        s7_pdn[i] <= s6_dir[i] * s6_nn[i];
      end
    end
  end

  // Sum for d.
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_inv  <= s7_inv;
      s8_num  <= s7_num;
      s8_den  <= s7_den;
      s8_den2 <= s7_den2;
      s8_dsum <= 53'(s7_pdn[0]) + 53'(s7_pdn[1]) + 53'(s7_pdn[2]);
      for (int i = 0; i < 3; i++) begin
        s8_dir[i] <= s7_dir[i];
        s8_nn[i]  <= s7_nn[i];
      end
    end
  end

  // d rescaled and clamped to [-1, 1].
  logic signed [63:0] d_c;
  always_comb begin
    d_c = round_shift(64'(s8_dsum), VECTOR_FRAC_BITS);
    if (d_c > (64'sd1 <<< IFRAC)) begin
      d_c = 64'sd1 <<< IFRAC;
    end else if (d_c < -(64'sd1 <<< IFRAC)) begin
      d_c = -(64'sd1 <<< IFRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_inv  <= s8_inv;
      s9_num  <= s8_num;
      s9_den  <= s8_den;
      s9_den2 <= s8_den2;
      s9_d    <= 32'(d_c);
      for (int i = 0; i < 3; i++) begin
        s9_dir[i] <= s8_dir[i];
        s9_nn[i]  <= s8_nn[i];
      end
    end
  end

  // d squared, ratio numerator squared, d times normal.
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_inv  <= s9_inv;
      s10_num  <= s9_num;
      s10_den  <= s9_den;
      s10_den2 <= s9_den2;
      s10_dd   <= 64'(s9_d) * 64'(s9_d);
      s10_nnum <= 32'(s9_num) * 32'(s9_num);
      for (int i = 0; i < 3; i++) begin
        s10_dir[i] <= s9_dir[i];
        s10_nn[i]  <= s9_nn[i];
        s10_dn[i]  <= s9_d * s9_nn[i];
      end
    end
  end

  // e = 1 - d^2 and the tangential term t = dir - d * norm.
  always_ff @(posedge clk) begin
    if (adv) begin
      s11_inv  <= s10_inv;
      s11_num  <= s10_num;
      s11_den  <= s10_den;
      s11_den2 <= s10_den2;
      s11_nnum <= s10_nnum;
      s11_e    <= 31'((64'sd1 <<< IFRAC) - round_shift(s10_dd, IFRAC));
      for (int i = 0; i < 3; i++) begin
        s11_nn[i] <= s10_nn[i];
        s11_t[i]  <= 34'(64'(s10_dir[i]) - round_shift(64'(s10_dn[i]), VECTOR_FRAC_BITS));
      end
    end
  end

  // num^2 * e and num * |t|.
  logic [33:0] tmag_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tmag_c[i] = s11_t[i][33] ? 34'(-s11_t[i]) : 34'(s11_t[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_inv  <= s11_inv;
      s12_den  <= s11_den;
      s12_den2 <= s11_den2;
      s12_nne  <= 63'(s11_nnum) * 63'(s11_e);
      for (int i = 0; i < 3; i++) begin
        s12_nn[i]   <= s11_nn[i];
        s12_pm[i]   <= 50'(s11_num) * 50'(tmag_c[i]);
        s12_pneg[i] <= !s11_t[i][33] && (s11_t[i] != '0);
      end
    end
  end

  // Scaled determinant numerator and rounded dividends for the ratio term.
  always_ff @(posedge clk) begin
    if (adv) begin
      s13_inv    <= s12_inv;
      s13_den    <= s12_den;
      s13_den2   <= s12_den2;
      s13_pneg   <= s12_pneg;
      s13_detnum <= $signed({2'b00, s12_den2, 30'd0}) - $signed({1'b0, s12_nne});
      for (int i = 0; i < 3; i++) begin
        s13_nn[i]   <= s12_nn[i];
        s13_pnum[i] <= 51'(s12_pm[i]) + 51'(s12_den >> 1);
      end
    end
  end

  // Total internal reflection test, overflow guard for the ratio quotients.
  always_ff @(posedge clk) begin
    if (adv) begin
      s14_side.inv  <= s13_inv;
      s14_side.tir  <= s13_detnum[63];
      s14_side.pneg <= s13_pneg;
      s14_den       <= s13_den;
      s14_den2      <= s13_den2;
      s14_dnum      <= s13_detnum[63] ? '0 : 64'(s13_detnum) + 64'(s13_den2 >> 1);
      for (int i = 0; i < 3; i++) begin
        s14_side.nn[i]   <= s13_nn[i];
        s14_side.povf[i] <= (s13_pnum[i] >> QUO_W) >= 51'(s13_den);
        s14_pnum[i]      <= s13_pnum[i];
      end
    end
  end

  // det = detnum / den^2 and the ratio terms num * t / den.
  rv_div u_det_div (
    .clk   (clk),
    .en    (adv),
    .numer (s14_dnum),
    .denom (s14_den2),
    .quo   (detq)
  );

  for (genvar i = 0; i < 3; i++) begin : g_ratio
    rv_div u_ratio_div (
      .clk   (clk),
      .en    (adv),
      .numer (DIVD_W'(s14_pnum[i])),
      .denom (DIVS_W'(s14_den)),
      .quo   (pquo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_c[0] <= s14_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        line_c[k] <= line_c[k-1];
      end
    end
  end

  // Signed ratio terms; a quotient too large for the divider saturates later.
  always_comb begin
    side_d_in.inv = line_c[DIV_STAGES-1].inv;
    side_d_in.tir = line_c[DIV_STAGES-1].tir;
    side_d_in.nn  = line_c[DIV_STAGES-1].nn;
    for (int i = 0; i < 3; i++) begin
      if (line_c[DIV_STAGES-1].povf[i]) begin
        side_d_in.p[i] = line_c[DIV_STAGES-1].pneg[i] ? -(36'd1 << QUO_W) : (36'd1 << QUO_W);
      end else begin
        side_d_in.p[i] = line_c[DIV_STAGES-1].pneg[i] ? -(36'(pquo[i])) : 36'(pquo[i]);
      end
    end
  end

  // sqrt(det) at 30 fraction bits.
  rv_isqrt u_det_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (RAD_W'(detq) << IFRAC),
    .root     (sq)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      line_d[0] <= side_d_in;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        line_d[k] <= line_d[k-1];
      end
    end
  end

  // Normal times sqrt(det).
  always_ff @(posedge clk) begin
    if (adv) begin
      s16_inv <= line_d[SQRT_STAGES-1].inv;
      s16_tir <= line_d[SQRT_STAGES-1].tir;
      for (int i = 0; i < 3; i++) begin
        s16_p[i]  <= $signed(line_d[SQRT_STAGES-1].p[i]);
        s16_qp[i] <= $signed(line_d[SQRT_STAGES-1].nn[i]) * $signed({1'b0, sq});
      end
    end
  end

  // Difference of the two terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      s17_inv <= s16_inv;
      s17_tir <= s16_tir;
      for (int i = 0; i < 3; i++) begin
        s17_diff[i] <= 38'(64'(s16_p[i]) - round_shift(64'(s16_qp[i]), VECTOR_FRAC_BITS));
      end
    end
  end

  // Output word: rescale, saturate, and force zero for the special cases.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (s17_inv || s17_tir) begin
          o_res[i] <= '0;
        end else begin
          o_res[i] <= sat_out(round_shift(64'(s17_diff[i]), IFRAC - VECTOR_FRAC_BITS));
        end
      end
      if (s17_inv) begin
        o_status <= ST_INVALID;
      end else if (s17_tir) begin
        o_status <= ST_TIR;
      end else begin
        o_status <= ST_REFRACTED;
      end
    end
  end

  assign result.valid       = o_valid;
  assign result.refracted_x = o_res[0];
  assign result.refracted_y = o_res[1];
  assign result.refracted_z = o_res[2];
  assign result.status      = o_status;

  // An invalid ray always leaves as a zero vector.
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == ST_INVALID |->
      o_res[0] == '0 && o_res[1] == '0 && o_res[2] == '0)
    else $error("invalid ray gave a non-zero vector");

  // Total internal reflection always leaves as a zero vector.
  a_tir_zero : assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status == ST_TIR |->
      o_res[0] == '0 && o_res[1] == '0 && o_res[2] == '0)
    else $error("total internal reflection gave a non-zero vector");

  // The normalising shift leaves the largest magnitude at or above 2^30.
  a_norm_range : assert property (@(posedge clk) disable iff (rst)
    s2_v && !s2_inv |->
      s2_mn[0][31:30] != 2'b00 || s2_mn[1][31:30] != 2'b00 || s2_mn[2][31:30] != 2'b00)
    else $error("normalised incident vector out of range");

endmodule
